@@ src/pssc_pkg.sv @@
`timescale 1ns / 1ps
package pssc_pkg;

  // Fixed scale of the level input and timing constants
  localparam int unsigned LEVEL_FULL    = 2000;
  localparam int unsigned LIMIT_BONUS_S = 120;
  localparam int unsigned MS_PER_S      = 1000;

  localparam int unsigned LEVEL_W = 11;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned TIME_W  = 32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEVEL  = 1'd1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_EVAL        = 3'd0,
    REQ_START       = 3'd1,
    REQ_STOP        = 3'd2,
    REQ_FORCE_START = 3'd3,
    REQ_FORCE_STOP  = 3'd4
  } req_e;

  // One input word
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] level;
    logic               reserve_ok;
    logic               sensor_fault;
    logic               wire_fault;
  } item_t;

  // Controller state (run limit kept apart, its width follows the parameters)
  typedef struct packed {
    logic              running;
    logic              timeout_fault;
    logic              dry_latched;
    logic [TIME_W-1:0] run_start_ms;
    logic [TIME_W-1:0] last_check_ms;
  } state_t;

endpackage

@@ src/pssc_item_if.sv @@
`timescale 1ns / 1ps
interface pssc_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] now_ms;
  logic [10:0] level;
  logic        reserve_ok;
  logic        sensor_fault;
  logic        wire_fault;

  modport source (
    output valid, req_type, now_ms, level, reserve_ok, sensor_fault, wire_fault,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, level, reserve_ok, sensor_fault, wire_fault,
    output ready
  );
endinterface

@@ src/pssc_result_if.sv @@
`timescale 1ns / 1ps
interface pssc_result_if;
  logic valid;
  logic ready;
  logic relay_on;
  logic pump_on;
  logic relay_fault;
  logic reserve_lost;

  modport source (
    output valid, relay_on, pump_on, relay_fault, reserve_lost,
    input  ready
  );
  modport sink (
    input  valid, relay_on, pump_on, relay_fault, reserve_lost,
    output ready
  );
endinterface

@@ src/pssc_decide.sv @@
`timescale 1ns / 1ps
module pssc_decide import pssc_pkg::*; #(
  parameter int unsigned CHECK_PERIOD_MS = 1000,
  parameter int unsigned LMS_W           = 26
) (
  input  item_t              item_i,
  input  logic [LEVEL_W-1:0] start_level_i,
  input  logic [LEVEL_W-1:0] stop_level_i,
  input  state_t             st_i,
  input  logic [LMS_W-1:0]   limit_ms_i,
  input  logic [LMS_W-1:0]   new_limit_ms_i,
  output state_t             st_o,
  output logic [LMS_W-1:0]   limit_ms_o
);

  localparam logic [TIME_W-1:0] CHECK_MS = TIME_W'(CHECK_PERIOD_MS);

  logic              reserve;
  logic              fault;
  logic [TIME_W-1:0] since_check;
  logic [TIME_W-1:0] run_time;
  logic              period_due;
  logic              timed_out;
  logic              can_start;
  logic              start;

  // Qualifiers used by the request decode below
  assign reserve     = item_i.reserve_ok & ~st_i.dry_latched;
  assign fault       = st_i.timeout_fault | item_i.sensor_fault | item_i.wire_fault;
  assign since_check = item_i.now_ms - st_i.last_check_ms;
  assign run_time    = item_i.now_ms - st_i.run_start_ms;
  assign period_due  = (since_check >= CHECK_MS);
  // elapsed/1000 >= limit_s is the same as elapsed >= limit_s*1000
  assign timed_out   = (run_time >= TIME_W'(limit_ms_i));
  assign can_start   = (item_i.level < stop_level_i) & ~st_i.running & reserve & ~fault;

  // Request decode and state update
  always_comb begin
    st_o  = st_i;
    start = 1'b0;
    unique case (req_e'(item_i.req_type))
      REQ_EVAL: begin
        if (!reserve) begin
          st_o.running = 1'b0;
        end else if (period_due) begin
          if (fault) begin
            st_o.running       = 1'b0;
            st_o.last_check_ms = item_i.now_ms;
          end else if (st_i.running) begin
            if (item_i.level >= stop_level_i) begin
              st_o.running = 1'b0;
            end
            if (timed_out) begin
              st_o.running       = 1'b0;
              st_o.timeout_fault = 1'b1;
              if (item_i.level <= stop_level_i) begin
                st_o.dry_latched = 1'b1;
              end
            end
            st_o.last_check_ms = item_i.now_ms;
          end else if (item_i.level <= start_level_i) begin
            // starting leaves the check time alone
            start = can_start;
          end else begin
            st_o.last_check_ms = item_i.now_ms;
          end
        end
      end
      REQ_START:                 start = can_start;
      REQ_STOP, REQ_FORCE_STOP:  st_o.running = 1'b0;
      REQ_FORCE_START:           start = 1'b1;
      default: ;
    endcase
    if (start) begin
      st_o.running      = 1'b1;
      st_o.run_start_ms = item_i.now_ms;
    end
  end

  assign limit_ms_o = start ? new_limit_ms_i : limit_ms_i;

endmodule

@@ src/pump_start_stop_controller_top.sv @@
`timescale 1ns / 1ps
// Pump start/stop controller.
// item_i carries one control sample per word: request code, time in ms,
// tank level and fault flags. result_o returns one word per sample with the
// relay drive, the running status and the two latched fault flags.
// cfg_we_i/cfg_idx_i/cfg_data_i write the start and stop levels; write them
// only while no word is in flight.
// A word taken from item_i passes the stage 1, 2 and 3 registers and the
// result register. The first two stages work out the run limit for the
// sample's level (one constant multiply, then a reciprocal multiply for the
// divide by 2000); the third updates the controller state and loads the
// result. Throughput: one word per cycle while result_o is not held; each
// stage forwards whenever the next one is free, so bubbles close up.
// Stall: while result_o is held, up to three more words are taken in before
// item_i.ready falls.
// Reset: pump off, faults clear, start level 0, stop level 2000, pipeline
// empty; the latched faults clear only by reset.
module pump_start_stop_controller_top import pssc_pkg::*; #(
  parameter int unsigned FULL_FILL_SECONDS = 1800,
  parameter int unsigned CHECK_PERIOD_MS   = 1000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pssc_item_if.sink            item_i,
  pssc_result_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  // Widths of the run limit path
  localparam int unsigned P_W     = $clog2(FULL_FILL_SECONDS * LEVEL_FULL + 1);
  localparam int unsigned A_W     = P_W - 4;
  localparam int unsigned K       = A_W + 7;
  localparam int unsigned M_W     = K - 6;
  localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'd124) / 64'd125;
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);
  localparam int unsigned Q_W     = $clog2(FULL_FILL_SECONDS + 1);
  localparam int unsigned LIM_MAX = (FULL_FILL_SECONDS > 2 * LIMIT_BONUS_S) ?
                                    FULL_FILL_SECONDS : 2 * LIMIT_BONUS_S;
  localparam int unsigned LIM_W   = $clog2(LIM_MAX + 1);
  localparam int unsigned LMS_W   = $clog2(LIM_MAX * MS_PER_S + 1);

  item_t s1_item_q, s2_item_q, s3_item_q;
  logic  s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic  load_out, move2, move1, take_in;
  logic  free3, free2;

  logic [LEVEL_W-1:0] lvl_clamp;
  logic [LEVEL_W-1:0] lvl_room;
  logic [P_W-1:0]     prod_d, prod_q;
  logic [A_W-1:0]     prod_div16;
  logic [A_W+M_W-1:0] recip_prod;
  logic [Q_W-1:0]     quot_d, quot_q;
  logic [LIM_W-1:0]   lim_s;
  logic [LMS_W-1:0]   lim_ms;

  logic [LEVEL_W-1:0] start_level_q, stop_level_q;
  state_t             st_q, st_d;
  logic [LMS_W-1:0]   limit_ms_q, limit_ms_d;

  // Pipeline flow: each stage moves when the one after it is free
  assign load_out = s3_vld_q & (~out_vld_q | result_o.ready);
  assign free3    = ~s3_vld_q | load_out;
  assign move2    = s2_vld_q & free3;
  assign free2    = ~s2_vld_q | move2;
  assign move1    = s1_vld_q & free2;
  assign item_i.ready = ~s1_vld_q | move1;
  assign take_in  = item_i.valid & item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (item_i.ready) s1_vld_q <= item_i.valid;
      if (free2)        s2_vld_q <= s1_vld_q;
      if (free3)        s3_vld_q <= s2_vld_q;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Stage 1: room left in the tank times the full fill time
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_item_q.req_type     <= item_i.req_type;
      s1_item_q.now_ms       <= item_i.now_ms;
      s1_item_q.level        <= item_i.level;
      s1_item_q.reserve_ok   <= item_i.reserve_ok;
      s1_item_q.sensor_fault <= item_i.sensor_fault;
      s1_item_q.wire_fault   <= item_i.wire_fault;
    end
  end

  // Levels above full count as full for the limit; the raw level goes on
  // for the compares
  assign lvl_clamp = (s1_item_q.level > LEVEL_W'(LEVEL_FULL)) ? LEVEL_W'(LEVEL_FULL)
                                                              : s1_item_q.level;
  assign lvl_room  = LEVEL_W'(LEVEL_FULL) - lvl_clamp;
  assign prod_d    = P_W'(FULL_FILL_SECONDS) * P_W'(lvl_room);

  always_ff @(posedge clk_i) begin
    if (move1) begin
      s2_item_q <= s1_item_q;
      prod_q    <= prod_d;
    end
  end

  // Stage 2: divide by 2000 as a shift by 4 and a reciprocal multiply for 125
  assign prod_div16 = A_W'(prod_q >> 4);
  assign recip_prod = (A_W+M_W)'(prod_div16) * (A_W+M_W)'(RECIP);
  assign quot_d     = Q_W'(recip_prod >> K);

  always_ff @(posedge clk_i) begin
    if (move2) begin
      s3_item_q <= s2_item_q;
      quot_q    <= quot_d;
    end
  end

  // Stage 3: short runs get the bonus, limit kept in ms
  assign lim_s  = (LIM_W'(quot_q) <= LIM_W'(LIMIT_BONUS_S)) ?
                  LIM_W'(quot_q) + LIM_W'(LIMIT_BONUS_S) : LIM_W'(quot_q);
  assign lim_ms = LMS_W'(lim_s) * LMS_W'(MS_PER_S);

  pssc_decide #(
    .CHECK_PERIOD_MS (CHECK_PERIOD_MS),
    .LMS_W           (LMS_W)
  ) u_decide (
    .item_i         (s3_item_q),
    .start_level_i  (start_level_q),
    .stop_level_i   (stop_level_q),
    .st_i           (st_q),
    .limit_ms_i     (limit_ms_q),
    .new_limit_ms_i (lim_ms),
    .st_o           (st_d),
    .limit_ms_o     (limit_ms_d)
  );

  // Controller state, updated as each word enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      limit_ms_q <= '0;
    end else if (load_out) begin
      st_q       <= st_d;
      limit_ms_q <= limit_ms_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_level_q <= '0;
      stop_level_q  <= LEVEL_W'(LEVEL_FULL);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_LEVEL: start_level_q <= cfg_data_i;
        CFG_STOP_LEVEL:  stop_level_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // State only moves when a new result loads, so it doubles as the result word
  assign result_o.valid        = out_vld_q;
  assign result_o.relay_on     = st_q.running;
  assign result_o.pump_on      = st_q.running;
  assign result_o.relay_fault  = st_q.timeout_fault;
  assign result_o.reserve_lost = st_q.dry_latched;

endmodule
